// ===== rtl/core/vgf_pkg.sv =====
// vgf_pkg: shared constants, codes and types for the valve gas flow block.
// No dependencies; used by vgf_choke and valve_gas_flow.
package vgf_pkg;

    // Register reset values and defaults for zero-programmed registers
    localparam logic [15:0] SG_RESET   = 16'd4096;
    localparam logic [15:0] K_RESET    = 16'd5734;
    localparam logic [15:0] XT_RESET   = 16'd45875;
    localparam logic [15:0] Z_RESET    = 16'd4096;
    localparam logic [15:0] ONE_Q12    = 16'd4096;
    localparam logic [15:0] XT_DEFAULT = 16'd45875;

    // Expansion factor limits, Q.30
    localparam logic [30:0] Y_ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] Y_FLOOR_Q30  = 31'd716185796;
    localparam logic [30:0] Y_CHOKED_Q30 = 31'd715827882;

    // 2.73 / 3.6e8 scaled by 2^60
    localparam logic [33:0] FLOW_CONST = 34'd8742988077;

    // ceil(2^37 / 7): exact floor division by 7 for dividends below 2^34
    localparam logic [34:0] RECIP7 = 35'd19634136211;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SPECIFIC_GRAVITY = 2'd0,
        REG_HEAT_RATIO       = 2'd1,
        REG_PRESSURE_RATIO   = 2'd2,
        REG_COMPRESSIBILITY  = 2'd3
    } reg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_NONCHOKED = 2'd0,
        STATUS_CHOKED    = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

    // Choke limit Fk*xT (Q.32) and three times it, from the config side
    typedef struct packed {
        logic [35:0] f;
        logic [37:0] f3;
    } choke_t;

endpackage

// ===== rtl/core/vgf_choke.sv =====
// vgf_choke: five-stage pipeline forming the choke limit F = k*xT*80/7 from config.
// Depends on vgf_pkg.
module vgf_choke (
    input  logic                 aclk,
    input  logic [15:0]          heat_ratio,
    input  logic [15:0]          xt_eff,
    output vgf_pkg::choke_t      choke
);

    logic [31:0] n_reg;
    logic [33:0] m3_reg;
    logic [35:0] e11_reg;
    logic [35:0] e11d_reg;
    logic [51:0] plo_reg;
    logic [50:0] phi_reg;
    logic [35:0] f_reg;
    logic [37:0] f3_reg;
    logic [69:0] prod_sum;
    logic [35:0] f_next;

    // floor(80n/7) = 11n + floor(3n/7); the last term by reciprocal multiply
    assign prod_sum = 70'(plo_reg) + (70'(phi_reg) << 18);
    assign f_next   = e11d_reg + 36'(prod_sum >> 37);

    always_ff @(posedge aclk) begin
        n_reg    <= 32'(heat_ratio) * 32'(xt_eff);
        m3_reg   <= 34'(n_reg) * 34'd3;
        e11_reg  <= 36'(n_reg) * 36'd11;
        plo_reg  <= 52'(m3_reg) * 52'(vgf_pkg::RECIP7[17:0]);
        phi_reg  <= 51'(m3_reg) * 51'(vgf_pkg::RECIP7[34:18]);
        e11d_reg <= e11_reg;
        f_reg    <= f_next;
        f3_reg   <= 38'(f_reg) * 38'd3;
    end

    assign choke.f  = f_reg;
    assign choke.f3 = f3_reg;

endmodule

// ===== rtl/core/vgf_div.sv =====
// vgf_div: pipelined restoring divider, one quotient bit per stage, with sideband.
// Expects in_rem below in_div; returns floor(in_rem * 2^QW / in_div). Uses no package items.
module vgf_div #(
    parameter int DW = 27,
    parameter int QW = 32,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] div_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic          valid_reg[QW];

    genvar i;
    for (i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] div_prev;
        logic [QW-1:0] quo_prev;
        logic [SW-1:0] side_prev;
        logic          valid_prev;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (i == 0) begin : g_first
            assign rem_prev   = in_rem;
            assign div_prev   = in_div;
            assign quo_prev   = '0;
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign rem_prev   = rem_reg[i-1];
            assign div_prev   = div_reg[i-1];
            assign quo_prev   = quo_reg[i-1];
            assign side_prev  = side_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        // shift in one numerator zero, subtract when it fits
        assign trial    = {rem_prev, 1'b0};
        assign ge       = trial >= {1'b0, div_prev};
        assign rem_next = ge ? DW'(trial - {1'b0, div_prev}) : trial[DW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                div_reg[i]  <= div_prev;
                quo_reg[i]  <= {quo_prev[QW-2:0], ge};
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== rtl/core/vgf_sqrt.sv =====
// vgf_sqrt: 32-stage integer square root of a 64-bit value, one result bit per stage.
// Carries a sideband alongside. Uses no package items.
module vgf_sqrt #(
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_val,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [31:0]   out_root,
    output logic [SW-1:0] out_side
);

    localparam int NS = 32;

    logic [63:0]   rem_reg  [NS];
    logic [63:0]   res_reg  [NS];
    logic [SW-1:0] side_reg [NS];
    logic          valid_reg[NS];

    genvar i;
    for (i = 0; i < NS; i++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0]   rem_prev;
        logic [63:0]   res_prev;
        logic [SW-1:0] side_prev;
        logic          valid_prev;
        logic [64:0]   trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_prev   = in_val;
            assign res_prev   = '0;
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign rem_prev   = rem_reg[i-1];
            assign res_prev   = res_reg[i-1];
            assign side_prev  = side_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        assign trial = {1'b0, res_prev} + {1'b0, BIT};
        assign ge    = {1'b0, rem_prev} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? rem_prev - trial[63:0] : rem_prev;
                res_reg[i]  <= ge ? (res_prev >> 1) + BIT : res_prev >> 1;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_root  = res_reg[NS-1][31:0];
    assign out_side  = side_reg[NS-1];

endmodule

// ===== rtl/core/valve_gas_flow.sv =====
// valve_gas_flow: top level of the gas valve flow pipeline.
// Depends on vgf_pkg, vgf_choke, vgf_div and vgf_sqrt.
//
// Usage:
//   Input stream s_*: one transaction per sensor sample (pressures, temperature,
//   Cv). Output stream m_*: one transaction per sample with the flow in Q12.20
//   m^3/s on m_tdata and the status code on m_tuser, in input order.
//   A sample is taken every cycle unless the pipeline is frozen (see below).
//   Most of the pipeline depth lies in the three bit-per-stage dividers (32, 30
//   and 64 stages) and the 32-stage square root.
//   Config writes (cfg_wr_en, cfg_index, cfg_wdata) are registered directly; the
//   choke limit derived from them settles through vgf_choke well before any
//   sample reaches the compare stage. Write only while the pipe is empty.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   register defaults.
//   When m_tready is low the pipeline keeps moving until the last stage before
//   the output register holds a sample, then freezes as a whole; nothing is
//   dropped or repeated.
module valve_gas_flow (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // upstream_pressure[26:0], downstream_pressure[53:27],
                                   // upstream_temperature[69:54], valve_coefficient[93:70]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // flow_rate[31:0]
    output logic [1:0]  m_tuser,   // flow_status[1:0]
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // sideband layouts through the long units
    typedef struct packed {
        logic        invalid;
        logic        full;
        logic [31:0] sgt;
        logic [50:0] pc;
    } xside_t;

    typedef struct packed {
        logic        invalid;
        logic        nonch;
        logic [35:0] r;
        logic [47:0] d;
        logic [50:0] pc;
    } yside_t;

    typedef struct packed {
        logic        invalid;
        logic        nonch;
        logic        sat;
        logic [56:0] pp0;
        logic [55:0] pp1;
    } vside_t;

    typedef struct packed {
        vgf_pkg::status_t status;
        logic [51:0]      p2;
    } qside_t;

    // configuration registers
    logic [15:0] sg_reg, k_reg, xt_reg, z_reg;
    logic [15:0] sg_eff, xt_eff, z_eff;
    vgf_pkg::choke_t choke;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sg_reg <= vgf_pkg::SG_RESET;
            k_reg  <= vgf_pkg::K_RESET;
            xt_reg <= vgf_pkg::XT_RESET;
            z_reg  <= vgf_pkg::Z_RESET;
        end else if (cfg_wr_en) begin
            unique case (vgf_pkg::reg_index_t'(cfg_index))
                vgf_pkg::REG_SPECIFIC_GRAVITY: sg_reg <= cfg_wdata;
                vgf_pkg::REG_HEAT_RATIO:       k_reg  <= cfg_wdata;
                vgf_pkg::REG_PRESSURE_RATIO:   xt_reg <= cfg_wdata;
                vgf_pkg::REG_COMPRESSIBILITY:  z_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign sg_eff = (sg_reg == '0) ? vgf_pkg::ONE_Q12    : sg_reg;
    assign xt_eff = (xt_reg == '0) ? vgf_pkg::XT_DEFAULT : xt_reg;
    assign z_eff  = (z_reg  == '0) ? vgf_pkg::ONE_Q12    : z_reg;

    vgf_choke u_choke (
        .aclk       (aclk),
        .heat_ratio (k_reg),
        .xt_eff     (xt_eff),
        .choke      (choke)
    );

    // global advance: move unless a sample is blocked at the output and another waits in stage 8
    logic en;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready || !v8_reg;
    assign s_tready = en;

    // stage 0: capture the sample
    logic [26:0] p1_0_reg, p2_0_reg;
    logic [15:0] t_0_reg;
    logic [23:0] cv_0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_0_reg <= s_tdata[26:0];
            p2_0_reg <= s_tdata[53:27];
            t_0_reg  <= s_tdata[69:54];
            cv_0_reg <= s_tdata[93:70];
        end
    end

    // stage 1: pressure drop, Cv*p1 and sg*T
    logic        invalid0, full0;
    logic [26:0] dp0;
    logic [26:0] xrem_1_reg, p1_1_reg;
    xside_t      xside_1_reg;

    assign invalid0 = (cv_0_reg == '0) || (p1_0_reg == '0) || (t_0_reg == '0);
    assign full0    = (p2_0_reg == '0);
    assign dp0      = (p1_0_reg > p2_0_reg) ? p1_0_reg - p2_0_reg : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            xrem_1_reg          <= full0 ? '0 : dp0;
            p1_1_reg            <= p1_0_reg;
            xside_1_reg.invalid <= invalid0;
            xside_1_reg.full    <= full0;
            xside_1_reg.sgt     <= 32'(sg_eff) * 32'(t_0_reg);
            xside_1_reg.pc      <= 51'(cv_0_reg) * 51'(p1_0_reg);
        end
    end

    // x = dp / p1 in Q.32
    logic        xdiv_valid;
    logic [31:0] xdiv_quo;
    xside_t      xdiv_side;

    vgf_div #(.DW(27), .QW(32), .SW($bits(xside_t))) u_xdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_rem    (xrem_1_reg),
        .in_div    (p1_1_reg),
        .in_side   (xside_1_reg),
        .out_valid (xdiv_valid),
        .out_quo   (xdiv_quo),
        .out_side  (xdiv_side)
    );

    // stage 2: x with the full-drop case, D = sg*T*Z
    logic [32:0] x_2_reg;
    logic [47:0] d_2_reg;
    logic [50:0] pc_2_reg;
    logic        inv_2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_2_reg   <= xdiv_side.full ? 33'h1_0000_0000 : {1'b0, xdiv_quo};
            d_2_reg   <= 48'(xdiv_side.sgt) * 48'(z_eff);
            pc_2_reg  <= xdiv_side.pc;
            inv_2_reg <= xdiv_side.invalid;
        end
    end

    // stage 3: choke decision and root ratio
    logic        nonch2;
    logic [37:0] yrem_3_reg;
    logic [37:0] f3_3_reg;
    yside_t      yside_3_reg;

    assign nonch2 = 36'(x_2_reg) < choke.f;

    always_ff @(posedge aclk) begin
        if (en) begin
            yrem_3_reg          <= nonch2 ? 38'(x_2_reg) : '0;
            f3_3_reg            <= choke.f3;
            yside_3_reg.invalid <= inv_2_reg;
            yside_3_reg.nonch   <= nonch2;
            yside_3_reg.r       <= nonch2 ? 36'(x_2_reg) : choke.f;
            yside_3_reg.d       <= d_2_reg;
            yside_3_reg.pc      <= pc_2_reg;
        end
    end

    // x / (3F) in Q.30 for the expansion factor
    logic        ydiv_valid;
    logic [29:0] ydiv_quo;
    yside_t      ydiv_side;

    vgf_div #(.DW(38), .QW(30), .SW($bits(yside_t))) u_ydiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rem    (yrem_3_reg),
        .in_div    (f3_3_reg),
        .in_side   (yside_3_reg),
        .out_valid (ydiv_valid),
        .out_quo   (ydiv_quo),
        .out_side  (ydiv_side)
    );

    // stage 4: expansion factor Y with its floor
    logic [30:0] y_lin;
    logic [30:0] y_4_reg;
    yside_t      side_4_reg;

    assign y_lin = vgf_pkg::Y_ONE_Q30 - 31'(ydiv_quo);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!ydiv_side.nonch) begin
                y_4_reg <= vgf_pkg::Y_CHOKED_Q30;
            end else if (y_lin < vgf_pkg::Y_FLOOR_Q30) begin
                y_4_reg <= vgf_pkg::Y_FLOOR_Q30;
            end else begin
                y_4_reg <= y_lin;
            end
            side_4_reg <= ydiv_side;
        end
    end

    // V = r * 2^54 / D, saturating when r/D reaches 1024; Cv*p1*Y partials
    logic [57:0] dsh4;
    logic        sat4;
    vside_t      vside4;

    assign dsh4           = {side_4_reg.d, 10'b0};
    assign sat4           = 58'(side_4_reg.r) >= dsh4;
    assign vside4.invalid = side_4_reg.invalid;
    assign vside4.nonch   = side_4_reg.nonch;
    assign vside4.sat     = sat4;
    assign vside4.pp0     = 57'(side_4_reg.pc[25:0]) * 57'(y_4_reg);
    assign vside4.pp1     = 56'(side_4_reg.pc[50:26]) * 56'(y_4_reg);

    logic        vdiv_valid;
    logic [63:0] vdiv_quo;
    vside_t      vdiv_side;

    vgf_div #(.DW(58), .QW(64), .SW($bits(vside_t))) u_vdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rem    (sat4 ? '0 : 58'(side_4_reg.r)),
        .in_div    (dsh4),
        .in_side   (vside4),
        .out_valid (vdiv_valid),
        .out_quo   (vdiv_quo),
        .out_side  (vdiv_side)
    );

    // stage 5: V with saturation, P = Cv*p1*Y >> 30, status
    logic [82:0] py_sum;
    logic [63:0] v_5_reg;
    qside_t      qside_5_reg;

    assign py_sum = 83'(vdiv_side.pp0) + (83'(vdiv_side.pp1) << 26);

    always_ff @(posedge aclk) begin
        if (en) begin
            v_5_reg        <= vdiv_side.sat ? '1 : vdiv_quo;
            qside_5_reg.p2 <= 52'(py_sum >> 30);
            if (vdiv_side.invalid) begin
                qside_5_reg.status <= vgf_pkg::STATUS_INVALID;
            end else if (vdiv_side.nonch) begin
                qside_5_reg.status <= vgf_pkg::STATUS_NONCHOKED;
            end else begin
                qside_5_reg.status <= vgf_pkg::STATUS_CHOKED;
            end
        end
    end

    // S = isqrt(V), root in Q.28
    logic        sq_valid;
    logic [31:0] sq_root;
    qside_t      sq_side;

    vgf_sqrt #(.SW($bits(qside_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_val    (v_5_reg),
        .in_side   (qside_5_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage 6-8: P*S >> 28, then times the flow constant
    logic [57:0]      a_6_reg, b_6_reg;
    logic [55:0]      p3_7_reg;
    logic [61:0]      c0_8_reg, c1_8_reg;
    vgf_pkg::status_t st_6_reg, st_7_reg, st_8_reg;
    logic [84:0]      ps_sum;

    assign ps_sum = 85'(a_6_reg) + (85'(b_6_reg) << 26);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_6_reg  <= 58'(sq_side.p2[25:0]) * 58'(sq_root);
            b_6_reg  <= 58'(sq_side.p2[51:26]) * 58'(sq_root);
            st_6_reg <= sq_side.status;
            p3_7_reg <= 56'(ps_sum >> 28);
            st_7_reg <= st_6_reg;
            c0_8_reg <= 62'(p3_7_reg[27:0]) * 62'(vgf_pkg::FLOW_CONST);
            c1_8_reg <= 62'(p3_7_reg[55:28]) * 62'(vgf_pkg::FLOW_CONST);
            st_8_reg <= st_7_reg;
        end
    end

    // output register: final shift, 32-bit saturation and zero flow for invalid samples
    logic [90:0] pc_sum;
    logic [41:0] p4;
    logic [31:0] flow_next;
    logic [31:0] flow_reg;
    logic [1:0]  status_reg;

    assign pc_sum    = 91'(c0_8_reg) + (91'(c1_8_reg) << 28);
    assign p4        = 42'(pc_sum >> 48);
    assign flow_next = (st_8_reg == vgf_pkg::STATUS_INVALID) ? '0 :
                       (p4[41:32] != '0) ? '1 : p4[31:0];

    always_ff @(posedge aclk) begin
        if (en && v8_reg) begin
            flow_reg   <= flow_next;
            status_reg <= st_8_reg;
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                v0_reg <= s_tvalid;
                v1_reg <= v0_reg;
                v2_reg <= xdiv_valid;
                v3_reg <= v2_reg;
                v4_reg <= ydiv_valid;
                v5_reg <= vdiv_valid;
                v6_reg <= sq_valid;
                v7_reg <= v6_reg;
                v8_reg <= v7_reg;
            end
            if (en && v8_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = flow_reg;
    assign m_tuser  = status_reg;

endmodule
